/* hw/rtl/pose_history_interpolator_defines.svh */
// Assertion macros shared by the pose history interpolator RTL.
`ifndef POSE_HISTORY_INTERPOLATOR_DEFINES_SVH
`define POSE_HISTORY_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PHI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PHI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/phi_pkg.sv */
// Shared types and constants of the pose history interpolator.
package phi_pkg;

    localparam int FIELD_W    = 32;
    localparam int NUM_FIELDS = 6;
    localparam int ENTRY_W    = FIELD_W * (NUM_FIELDS + 1);
    localparam int ALPHA_BITS = 24;
    localparam int LIMIT_W    = 11;
    localparam int OUT_W      = 240;

    typedef enum logic [1:0] {
        ST_REC    = 2'd0,
        ST_POSE   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_NOPAIR = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    take_first;
        logic    clamp;
        logic    scan_start;
        logic    scan_go;
        logic    hit;
        logic    div_step;
        logic    mul;
        logic    acc;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_func;
        logic empty;
        logic le_first;
        logic ge_last;
        logic hit;
        logic last_pair;
        logic span_zero;
        logic div_done;
        logic mul_last;
        logic out_free;
    } t_sts;

endpackage

/* hw/rtl/pose_history_interpolator.sv */
// Record: the request goes straight to the done state; one request is in work at a time.
// Query: an empty ring gives an empty result; a stamp at or before the first entry or at
// or after the last is clamped to that entry; else pairs are scanned (one per cycle through
// the pose memory read port), then 25 divide steps (none on a zero span) and six multiplies.
// A finished result waits in the output register while the next request is taken.
// Reset clears control and the ring (limit 1024); memory contents are not cleared.
`include "pose_history_interpolator_defines.svh"
module pose_history_interpolator #(
    parameter int DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [phi_pkg::LIMIT_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // time_stamp, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle
    input  logic [phi_pkg::ENTRY_W-1:0]        s_axis_tdata,
    // func
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_time, out_x, out_y, out_z, out_roll, out_pitch, out_yaw, entry_count, pad
    output logic [phi_pkg::OUT_W-1:0]          m_axis_tdata,
    // status
    output logic [1:0]                         m_axis_tuser
);
    import phi_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    phi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    phi_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_data    (s_axis_tdata),
        .i_in_func    (s_axis_tuser[0]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

    // one request in work at a time
    `PHI_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")
    // record results carry no pose
    `PHI_ASSERT_NOW(a_rec_zero, m_axis_tvalid && (m_axis_tuser == ST_REC), m_axis_tdata[223:0] == '0, "record result not zero")
    // error results carry no pose
    `PHI_ASSERT_NOW(a_err_zero, m_axis_tvalid && ((m_axis_tuser == ST_EMPTY) || (m_axis_tuser == ST_NOPAIR)), m_axis_tdata[223:0] == '0, "error result not zero")

endmodule

/* hw/rtl/phi_ctrl.sv */
// Sequencer for record, clamp, scan, divide and interpolate steps.
module phi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  phi_pkg::t_sts i_sts,
    output phi_pkg::t_cmd o_cmd
);
    import phi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CHK_FIRST = 8'b0000_0010,
        S_CHK_LAST  = 8'b0000_0100,
        S_SCAN      = 8'b0000_1000,
        S_DIV       = 8'b0001_0000,
        S_MUL       = 8'b0010_0000,
        S_ACC       = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_sts.in_func) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_REC;
                        n_state          = S_DONE;
                    end else if (i_sts.empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_EMPTY;
                        n_state          = S_DONE;
                    end else begin
                        n_state = S_CHK_FIRST;
                    end
                end
            end
            S_CHK_FIRST: begin
                o_cmd.take_first = 1'b1;
                if (i_sts.le_first) begin
                    o_cmd.clamp      = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_POSE;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_CHK_LAST;
                end
            end
            S_CHK_LAST: begin
                if (i_sts.ge_last) begin
                    o_cmd.clamp      = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_POSE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.hit        = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_POSE;
                    n_state          = i_sts.span_zero ? S_MUL : S_DIV;
                end else if (i_sts.last_pair) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOPAIR;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.scan_go = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.mul_last ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* hw/rtl/phi_dp.sv */
// Datapath: pose ring memory, bracket scan, serial divider, lerp unit, output register.
module phi_dp #(
    parameter int DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [phi_pkg::LIMIT_W-1:0]     i_cfg_data,
    input  logic [phi_pkg::ENTRY_W-1:0]     i_in_data,
    input  logic                            i_in_func,
    input  phi_pkg::t_cmd                   i_cmd,
    output phi_pkg::t_sts                   o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [phi_pkg::OUT_W-1:0]       o_out_data,
    output logic [1:0]                      o_out_status
);
    import phi_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data, r_a, r_b, r_res;
    logic [LIMIT_W-1:0] r_lim;
    logic [CW-1:0]      r_held, r_cnt;
    logic [AW-1:0]      r_oldest, r_ptr;
    logic [FIELD_W-1:0] r_t, r_rem, r_span;
    logic [ALPHA_BITS:0] r_alpha;
    logic [4:0]         r_dcnt;
    logic [2:0]         r_fidx;
    logic signed [58:0] r_prod;
    t_status            r_status;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic [1:0]         r_out_status;

    logic [CW-1:0]      w_eff;
    logic [CW:0]        w_sum_wr, w_sum_last, w_sum_nold, w_sum_nptr;
    logic [AW-1:0]      w_wr_slot, w_last_slot, w_next_old, w_next_ptr, w_rd_addr;
    logic               w_full;
    logic [FIELD_W-1:0] w_ta, w_tb;
    logic [FIELD_W:0]   w_rem_x;
    logic               w_ge;
    logic [FIELD_W-1:0] w_fa, w_fb;
    logic signed [32:0] w_d;
    logic signed [58:0] w_prod, w_rsum;

    // effective ring size
    always_comb begin
        if (r_lim == '0)                     w_eff = CW'(1);
        else if (32'(r_lim) > 32'(DEPTH))    w_eff = CW'(DEPTH);
        else                                 w_eff = CW'(r_lim);
    end

    // ring slot arithmetic, each sum stays below twice the ring size
    assign w_full     = (r_held >= w_eff);
    assign w_sum_wr   = {1'b0, CW'(r_oldest)} + {1'b0, r_held};
    assign w_sum_last = w_sum_wr - (CW+1)'(1);
    assign w_sum_nold = {1'b0, CW'(r_oldest)} + (CW+1)'(1);
    assign w_sum_nptr = {1'b0, CW'(r_ptr)} + (CW+1)'(1);
    assign w_wr_slot  = w_full ? r_oldest :
                        AW'((w_sum_wr >= {1'b0, w_eff}) ? w_sum_wr - {1'b0, w_eff} : w_sum_wr);
    assign w_last_slot = AW'((w_sum_last >= {1'b0, w_eff}) ? w_sum_last - {1'b0, w_eff}
                                                             : w_sum_last);
    assign w_next_old = (w_sum_nold == {1'b0, w_eff}) ? '0 : AW'(w_sum_nold);
    assign w_next_ptr = (w_sum_nptr == {1'b0, w_eff}) ? '0 : AW'(w_sum_nptr);

    // read address: first entry, then last, then walking pointer
    always_comb begin
        if (i_cmd.accept)          w_rd_addr = r_oldest;
        else if (i_cmd.take_first) w_rd_addr = w_last_slot;
        else if (i_cmd.scan_start) w_rd_addr = w_next_old;
        else                       w_rd_addr = w_next_ptr;
    end

    // pose memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_in_func) mem[w_wr_slot] <= i_in_data;
        r_rd_data <= mem[w_rd_addr];
    end

    assign w_ta = r_a[FIELD_W-1:0];
    assign w_tb = r_rd_data[FIELD_W-1:0];

    // restoring divide step, first step has no shift
    assign w_rem_x = (r_dcnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign w_ge    = (w_rem_x >= {1'b0, r_span});

    // lerp: one field per multiply and accumulate pair
    assign w_fa   = r_a[FIELD_W*r_fidx + FIELD_W +: FIELD_W];
    assign w_fb   = r_b[FIELD_W*r_fidx + FIELD_W +: FIELD_W];
    assign w_d    = $signed({w_fb[FIELD_W-1], w_fb}) - $signed({w_fa[FIELD_W-1], w_fa});
    assign w_prod = w_d * $signed({1'b0, r_alpha});
    assign w_rsum = r_prod + 59'sd8388608;

    // ring control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim    <= LIMIT_W'(1024);
            r_held   <= '0;
            r_oldest <= '0;
        end else if (i_cfg_valid) begin
            r_lim    <= i_cfg_data;
            r_held   <= '0;
            r_oldest <= '0;
        end else if (i_cmd.accept && !i_in_func) begin
            if (w_full) begin
                r_held   <= w_eff;
                r_oldest <= w_next_old;
            end else begin
                r_held <= r_held + CW'(1);
            end
        end
    end

    // query working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_t   <= i_in_data[FIELD_W-1:0];
            r_res <= '0;
        end
        if (i_cmd.set_status) r_status <= i_cmd.status;
        if (i_cmd.take_first) r_a <= r_rd_data;
        if (i_cmd.clamp)      r_res <= r_rd_data;
        if (i_cmd.scan_start) begin
            r_ptr <= w_next_old;
            r_cnt <= r_held - CW'(1);
        end
        if (i_cmd.scan_go) begin
            r_a   <= r_rd_data;
            r_ptr <= w_next_ptr;
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.hit) begin
            r_b                 <= r_rd_data;
            r_span              <= w_tb - w_ta;
            r_rem               <= r_t - w_ta;
            r_alpha             <= '0;
            r_dcnt              <= '0;
            r_fidx              <= '0;
            r_res[FIELD_W-1:0]  <= r_t;
        end
        if (i_cmd.div_step) begin
            r_rem   <= w_ge ? FIELD_W'(w_rem_x - {1'b0, r_span}) : FIELD_W'(w_rem_x);
            r_alpha <= {r_alpha[ALPHA_BITS-1:0], w_ge};
            r_dcnt  <= r_dcnt + 5'd1;
        end
        if (i_cmd.mul) r_prod <= w_prod;
        if (i_cmd.acc) begin
            r_res[FIELD_W*r_fidx + FIELD_W +: FIELD_W] <= w_fa + w_rsum[55:24];
            r_fidx <= r_fidx + 3'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_data   <= {5'd0, LIMIT_W'(r_held), r_res};
            r_out_status <= r_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

    // status back to the controller
    always_comb begin
        o_sts           = '0;
        o_sts.in_func   = i_in_func;
        o_sts.empty     = (r_held == '0);
        o_sts.le_first  = (r_t <= w_tb);
        o_sts.ge_last   = (r_t >= w_tb);
        o_sts.hit       = (w_ta <= r_t) && (r_t <= w_tb);
        o_sts.last_pair = (r_cnt == CW'(1));
        o_sts.span_zero = (w_ta == w_tb);
        o_sts.div_done  = (r_dcnt == 5'(ALPHA_BITS));
        o_sts.mul_last  = (r_fidx == 3'(NUM_FIELDS - 1));
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

endmodule

/* sim/pose_history_interpolator_test.sv */
// Self-checking testbench of the pose history interpolator: record and query traffic.
module pose_history_interpolator_test;
    import phi_pkg::*;

    // Items sent into the block and results expected from it
    typedef struct packed {
        logic                 func;
        logic [31:0]          stamp;
        logic [5:0][31:0]     pose;
    } t_pose_req;

    typedef struct packed {
        t_status              status;
        logic [31:0]          stamp;
        logic [5:0][31:0]     pose;
        logic [10:0]          count;
    } t_pose_result;

    localparam int RING = 1024;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [ENTRY_W-1:0]   s_axis_tdata;
    logic [0:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    pose_history_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the pose ring
    logic [31:0]      ring_time [0:RING-1];
    logic [5:0][31:0] ring_pose [0:RING-1];
    int unsigned      ring_oldest;
    int unsigned      ring_held;
    int unsigned      ring_limit;

    t_pose_req        pending_reqs [$];
    t_pose_result     expected_poses [$];
    t_pose_req        cur_req;
    logic             req_busy;
    logic             calm;
    int               errors;
    int               n_sent;
    int               n_checked;
    int               n_interp;
    logic [31:0]      gen_time;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned active_limit();
        if (ring_limit == 0) return 1;
        if (ring_limit > RING) return RING;
        return ring_limit;
    endfunction

    function automatic int unsigned ring_slot(int unsigned k);
        return (ring_oldest + k) % active_limit();
    endfunction

    // Linear blend, round to nearest with ties upward
    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [63:0] alpha);
        logic signed [63:0] av, d, p;
        av = {{32{a[31]}}, a};
        d  = {{32{b[31]}}, b} - av;
        p  = d * $signed(alpha) + 64'sd8388608;
        return 32'(av + (p >>> ALPHA_BITS));
    endfunction

    task automatic predict_pose(input t_pose_req rq);
        t_pose_result r;
        int unsigned  lim, s, first, last, a, b;
        logic [63:0]  span, dt, alpha;
        lim = active_limit();
        r = '0;
        if (rq.func == 1'b0) begin
            if (ring_held >= lim) begin
                ring_held = lim;
                s = ring_oldest % lim;
                ring_oldest = (s + 1) % lim;
            end else begin
                s = ring_slot(ring_held);
                ring_held++;
            end
            ring_time[s] = rq.stamp;
            ring_pose[s] = rq.pose;
            r.status = ST_REC;
        end else if (ring_held == 0) begin
            r.status = ST_EMPTY;
        end else begin
            first = ring_slot(0);
            last  = ring_slot(ring_held - 1);
            if (rq.stamp <= ring_time[first]) begin
                r.status = ST_POSE;
                r.stamp = ring_time[first];
                r.pose = ring_pose[first];
            end else if (rq.stamp >= ring_time[last]) begin
                r.status = ST_POSE;
                r.stamp = ring_time[last];
                r.pose = ring_pose[last];
            end else begin
                r.status = ST_NOPAIR;
                for (int unsigned k = 0; k + 1 < ring_held; k++) begin
                    a = ring_slot(k);
                    b = ring_slot(k + 1);
                    if (ring_time[a] <= rq.stamp && rq.stamp <= ring_time[b]) begin
                        span = ring_time[b] - ring_time[a];
                        dt = rq.stamp - ring_time[a];
                        alpha = (span != 0) ? (dt << ALPHA_BITS) / span : 64'd0;
                        r.status = ST_POSE;
                        r.stamp = rq.stamp;
                        for (int f = 0; f < 6; f++)
                            r.pose[f] = blend(ring_pose[a][f], ring_pose[b][f], alpha);
                        n_interp++;
                        break;
                    end
                end
            end
        end
        r.count = ring_held[10:0];
        expected_poses.insert(expected_poses.size(), r);
    endtask

    // Request driver: data changes at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && !req_busy) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
                cur_req = pending_reqs.pop_front();
                s_axis_tdata  <= {cur_req.pose, cur_req.stamp};
                s_axis_tuser  <= cur_req.func;
                s_axis_tvalid <= 1'b1;
                req_busy      <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end

    // Accepted requests feed the predictor
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            predict_pose(cur_req);
            n_sent++;
            req_busy <= 1'b0;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_pose_result e;
        logic [234:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_poses.size() == 0) begin
                $display("%0t unexpected result: status %0d data %h", $time,
                         m_axis_tuser, m_axis_tdata[234:0]);
                errors++;
            end else begin
                e = expected_poses.pop_front();
                want = {e.count, e.pose, e.stamp};
                if (m_axis_tuser != e.status || m_axis_tdata[234:0] != want) begin
                    $display("%0t mismatch: expected status %0d data %h, actual status %0d data %h",
                             $time, e.status, want, m_axis_tuser, m_axis_tdata[234:0]);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    task automatic queue_req(input logic func, input logic [31:0] stamp,
                             input logic [5:0][31:0] pose);
        t_pose_req rq;
        rq.func = func;
        rq.stamp = stamp;
        rq.pose = pose;
        pending_reqs.insert(pending_reqs.size(), rq);
    endtask

    function automatic logic [5:0][31:0] rand_pose();
        logic [5:0][31:0] p;
        for (int f = 0; f < 6; f++) p[f] = $urandom;
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_busy || expected_poses.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Limit write, only with nothing in flight
    task automatic write_limit(input logic [10:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ring_limit = value;
        ring_held = 0;
        ring_oldest = 0;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly ascending records with random queries, most within or just past the recorded span
    task automatic random_burst(input int n);
        logic [31:0] lo, t;
        lo = gen_time;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: queue_req(1'b0, $urandom, rand_pose());
                1, 2, 3: begin
                    t = lo + $urandom_range(gen_time - lo + 200);
                    if ($urandom_range(9) == 0) t = $urandom;
                    queue_req(1'b1, t, rand_pose());
                end
                default: begin
                    gen_time = gen_time + (($urandom_range(5) == 0) ? 0 : $urandom_range(3000));
                    queue_req(1'b0, gen_time, rand_pose());
                end
            endcase
        end
    endtask

    initial begin
        logic [5:0][31:0] pmin, pmax;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        req_busy = 1'b0;
        calm = 1'b0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_interp = 0;
        ring_limit = RING;
        ring_held = 0;
        ring_oldest = 0;
        for (int f = 0; f < 6; f++) begin
            pmin[f] = 32'h8000_0000;
            pmax[f] = 32'h7FFF_FFFF;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty history, clamps, extreme blends and time extremes
        queue_req(1'b1, 32'd50, rand_pose());
        queue_req(1'b0, 32'd1000, pmin);
        queue_req(1'b0, 32'd3000, pmax);
        queue_req(1'b1, 32'd500, rand_pose());
        queue_req(1'b1, 32'd5000, rand_pose());
        queue_req(1'b1, 32'd1000, rand_pose());
        queue_req(1'b1, 32'd3000, rand_pose());
        queue_req(1'b1, 32'd2000, rand_pose());
        queue_req(1'b1, 32'd1001, rand_pose());
        queue_req(1'b1, 32'd2999, rand_pose());
        queue_req(1'b0, 32'hFFFF_FFFF, pmin);
        queue_req(1'b1, 32'hFFFF_FFFE, rand_pose());
        queue_req(1'b1, 32'hFFFF_FFFF, rand_pose());
        queue_req(1'b0, 32'd3000, rand_pose());
        queue_req(1'b1, 32'd3000, rand_pose());
        queue_req(1'b0, 32'd0, rand_pose());
        queue_req(1'b1, 32'd1500, rand_pose());
        queue_req(1'b1, 32'd0, rand_pose());

        // Tiny ring wraps straight away
        write_limit(11'd3);
        for (int i = 0; i < 5; i++) queue_req(1'b0, 32'd100 * (i + 1), rand_pose());
        queue_req(1'b1, 32'd450, rand_pose());
        queue_req(1'b1, 32'd100, rand_pose());

        gen_time = 32'd10;
        write_limit(11'd0);
        random_burst(40);
        write_limit(11'd1);
        random_burst(40);
        write_limit(11'd2047);
        random_burst(40);
        write_limit(11'd17);
        calm = 1'b1;
        random_burst(80);
        wait_drained();
        calm = 1'b0;
        random_burst(40);
        write_limit(11'd64);
        gen_time = 32'hFFF0_0000;
        random_burst(70);
        write_limit(11'd1024);
        gen_time = 32'd0;
        random_burst(40);
        for (int i = 0; i < 3; i++) begin
            write_limit(11'($urandom_range(2, 40)));
            gen_time = $urandom_range(32'h8000_0000);
            random_burst(55);
        end

        wait_drained();
        repeat (1200) @(posedge i_clk);
        $display("Covered %0d requests over limits 0 to 2047, %0d results checked, %0d blended.",
                 n_sent, n_checked, n_interp);
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
